// File: hw/rtl/afnc_pkg.sv
// Package for the audio file name checker: codes, constants and character helpers.
package afnc_pkg;

   // Verdict codes returned on the end item
   typedef enum logic [2:0] {
      VERDICT_OK            = 3'd0,
      VERDICT_EMPTY         = 3'd1,
      VERDICT_TOO_LONG      = 3'd2,
      VERDICT_LEADING_DOT   = 3'd3,
      VERDICT_CONTROL       = 3'd4,
      VERDICT_FORBIDDEN     = 3'd5,
      VERDICT_TRAILING      = 3'd6,
      VERDICT_NOT_WAV       = 3'd7
   } verdict_type;

   // Kind of the first offending character
   typedef enum logic [1:0] {
      BAD_NONE      = 2'd0,
      BAD_CONTROL   = 2'd1,
      BAD_FORBIDDEN = 2'd2
   } bad_kind_type;

   localparam int          CharWidth       = 8;
   localparam int          LengthWidth     = 9;
   localparam int          RecentDepth     = 4;
   localparam logic [7:0]  MaxLengthReset  = 8'd64;
   localparam logic [8:0]  LengthSat       = 9'd256;
   localparam logic [8:0]  ExtMinLength    = 9'd4;

   localparam logic [7:0]  CharSpace       = 8'h20;
   localparam logic [7:0]  CharDelete      = 8'h7F;
   localparam logic [7:0]  CharDot         = 8'h2E;
   localparam logic [7:0]  CharLowerW      = 8'h77;
   localparam logic [7:0]  CharLowerA      = 8'h61;
   localparam logic [7:0]  CharLowerV      = 8'h76;

   // Classify one byte: control, one of the nine FAT-forbidden characters, or fine
   function automatic bad_kind_type classify(input logic [7:0] c);
      bad_kind_type kind;
      kind = BAD_NONE;
      if (c < CharSpace || c == CharDelete) begin
         kind = BAD_CONTROL;
      end else begin
         case (c)
            8'h22, 8'h2A, 8'h2F, 8'h3A, 8'h3C,
            8'h3E, 8'h3F, 8'h5C, 8'h7C: kind = BAD_FORBIDDEN;
            default:                    kind = BAD_NONE;
         endcase
      end
      return kind;
   endfunction

   // Fold ASCII upper case letters to lower case, leave every other byte alone
   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] result;
      result = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         result = c + 8'h20;
      end
      return result;
   endfunction

endpackage

// File: hw/rtl/audio_file_name_checker_core.sv
// Audio file name checker: streams name bytes and returns one verdict per name.
// The verdict appears on rsp_ in the cycle after its end item is accepted.
// Throughput: one item per cycle; the result register keeps taking items while
// rsp_ready is high, and req_ready drops only while an unread verdict is stalled.
// Reset (synchronous, active high) clears the name state and the valid flag of the result
// register (not the verdict itself) and sets the length limit to 64; csr_ready is always high.
module audio_file_name_checker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_name_character,
   input  logic       req_end_of_name,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_verdict,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_name_length
);

   logic [7:0]                      max_len_ff;
   logic [afnc_pkg::LengthWidth-1:0] name_length_ff, name_length_in;
   logic                            leading_dot_ff, leading_dot_in;
   afnc_pkg::bad_kind_type          bad_kind_ff, bad_kind_in;
   logic [afnc_pkg::CharWidth-1:0]  recent_ff [afnc_pkg::RecentDepth];
   logic [afnc_pkg::CharWidth-1:0]  recent_in [afnc_pkg::RecentDepth];
   logic                            rsp_valid_ff, rsp_valid_in;
   afnc_pkg::verdict_type           verdict_ff, verdict_in, judged;
   logic                            req_take;
   logic                            is_wav;

   // Accept while the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Judge the name held in the state registers
   always_comb begin
      is_wav = name_length_ff > afnc_pkg::ExtMinLength &&
               recent_ff[3] == afnc_pkg::CharDot &&
               afnc_pkg::lower_ascii(recent_ff[2]) == afnc_pkg::CharLowerW &&
               afnc_pkg::lower_ascii(recent_ff[1]) == afnc_pkg::CharLowerA &&
               afnc_pkg::lower_ascii(recent_ff[0]) == afnc_pkg::CharLowerV;
      if (name_length_ff == '0) begin
         judged = afnc_pkg::VERDICT_EMPTY;
      end else if (name_length_ff >= {1'b0, max_len_ff}) begin
         judged = afnc_pkg::VERDICT_TOO_LONG;
      end else if (leading_dot_ff) begin
         judged = afnc_pkg::VERDICT_LEADING_DOT;
      end else if (bad_kind_ff == afnc_pkg::BAD_CONTROL) begin
         judged = afnc_pkg::VERDICT_CONTROL;
      end else if (bad_kind_ff == afnc_pkg::BAD_FORBIDDEN) begin
         judged = afnc_pkg::VERDICT_FORBIDDEN;
      end else if (recent_ff[0] == afnc_pkg::CharSpace ||
                   recent_ff[0] == afnc_pkg::CharDot) begin
         judged = afnc_pkg::VERDICT_TRAILING;
      end else if (!is_wav) begin
         judged = afnc_pkg::VERDICT_NOT_WAV;
      end else begin
         judged = afnc_pkg::VERDICT_OK;
      end
   end

   // Next state of the name registers and the result register
   always_comb begin
      name_length_in = name_length_ff;
      leading_dot_in = leading_dot_ff;
      bad_kind_in    = bad_kind_ff;
      recent_in      = recent_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      verdict_in     = verdict_ff;
      if (req_take) begin
         if (req_end_of_name) begin
            // Emit the verdict and clear the name state
            rsp_valid_in   = 1'b1;
            verdict_in     = judged;
            name_length_in = '0;
            leading_dot_in = 1'b0;
            bad_kind_in    = afnc_pkg::BAD_NONE;
            for (int i = 0; i < afnc_pkg::RecentDepth; i++) begin
               recent_in[i] = '0;
            end
         end else begin
            // Record one character
            if (name_length_ff == '0 && req_name_character == afnc_pkg::CharDot) begin
               leading_dot_in = 1'b1;
            end
            if (bad_kind_ff == afnc_pkg::BAD_NONE) begin
               bad_kind_in = afnc_pkg::classify(req_name_character);
            end
            for (int i = afnc_pkg::RecentDepth - 1; i > 0; i--) begin
               recent_in[i] = recent_ff[i-1];
            end
            recent_in[0] = req_name_character;
            if (name_length_ff < afnc_pkg::LengthSat) begin
               name_length_in = name_length_ff + 9'd1;
            end
         end
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff     <= afnc_pkg::MaxLengthReset;
         name_length_ff <= '0;
         leading_dot_ff <= 1'b0;
         bad_kind_ff    <= afnc_pkg::BAD_NONE;
         for (int i = 0; i < afnc_pkg::RecentDepth; i++) begin
            recent_ff[i] <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_name_length;
         end
         name_length_ff <= name_length_in;
         leading_dot_ff <= leading_dot_in;
         bad_kind_ff    <= bad_kind_in;
         recent_ff      <= recent_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // An accepted end item always shows a verdict in the next cycle
   a_end_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_name |=> rsp_valid)
      else $error("end item accepted without a verdict");

   // An end item leaves the name state cleared
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_name |=>
         name_length_ff == '0 && !leading_dot_ff && bad_kind_ff == afnc_pkg::BAD_NONE)
      else $error("name state not cleared after end item");

   // Length never passes the saturation point
   a_length_sat: assert property (@(posedge clock) disable iff (reset)
      name_length_ff <= afnc_pkg::LengthSat)
      else $error("name length beyond saturation");

   // A recorded bad character stays recorded until the name ends
   a_bad_sticky: assert property (@(posedge clock) disable iff (reset)
      bad_kind_ff != afnc_pkg::BAD_NONE && !(req_valid && req_ready && req_end_of_name)
         |=> $stable(bad_kind_ff))
      else $error("first bad character kind changed mid name");

   // A character item never raises a verdict on its own
   a_char_no_verdict: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_end_of_name) |=> !rsp_valid)
      else $error("verdict without an end item");

endmodule
